// File: hw/rtl/fsia_pkg.sv
// Shared types and constants for the four-state integer ALU.
// Holds the opcode codes and the packed payload structs of both channels.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fsia_pkg;

  localparam int FIELD_W       = 64;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int OPCODE_W      = 3;
  localparam int CFG_WIDTH_W   = 7;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REM = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LT  = 3'd5;

  localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [FIELD_W-1:0]  operand_a;
    logic [FIELD_W-1:0]  operand_b;
    logic                a_unknown;
    logic                b_unknown;
    logic                both_signed;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_value;
    logic               result_unknown;
  } result_t;

endpackage

// File: hw/rtl/fsia_core.sv
// Sequencer and datapath of the four-state integer ALU.
// One shared adder serves add, subtract, compare, negation, shift-add
// multiply and restoring divide. Depends on fsia_pkg.
`timescale 1ns / 1ps

module fsia_core #(
  parameter int DATA_WIDTH = fsia_pkg::MAX_WIDTH_DEF,
  parameter int WIDTH_W    = $clog2(DATA_WIDTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [WIDTH_W-1:0] width,
  input  logic               item_valid,
  output logic               item_ready,
  input  fsia_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output fsia_pkg::result_t  result
);
  import fsia_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int IW = $clog2(DW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALU   = 3'd1;
  localparam logic [2:0] S_NEG_A = 3'd2;
  localparam logic [2:0] S_NEG_B = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;

  logic [2:0]          state;
  logic [OPCODE_W-1:0] op;
  logic [DW-1:0]       opa;
  logic [DW-1:0]       opb;
  logic [DW-1:0]       acc;
  logic [DW-1:0]       quo;
  logic [WIDTH_W-1:0]  cnt;
  logic                neg_a;
  logic                neg_b;
  logic [DW-1:0]       res;
  logic                res_unknown;

  logic [DW-1:0]       mask;
  logic [WIDTH_W-1:0]  width_m1;
  logic [WIDTH_W-1:0]  cnt_m1;
  logic [DW-1:0]       in_a;
  logic [DW-1:0]       in_b;
  logic                in_neg_a;
  logic                in_neg_b;
  logic                div_bit;
  logic [DW:0]         add_x;
  logic [DW:0]         add_y;
  logic                add_sub;
  logic [DW+1:0]       sum;
  logic                carry;
  logic                fix_neg;
  logic [DW-1:0]       fix_val;

  assign mask     = ~({DW{1'b1}} << width);
  assign width_m1 = width - 1'b1;
  assign cnt_m1   = cnt - 1'b1;
  assign in_a     = DW'(item.operand_a) & mask;
  assign in_b     = DW'(item.operand_b) & mask;
  assign in_neg_a = item.both_signed & in_a[width_m1[IW-1:0]];
  assign in_neg_b = item.both_signed & in_b[width_m1[IW-1:0]];
  assign div_bit  = opa[cnt_m1[IW-1:0]];

  // Remainder follows the dividend's sign; product and quotient follow both.
  assign fix_neg = (op == OP_REM) ? neg_a : (neg_a ^ neg_b);
  assign fix_val = (op == OP_DIV) ? quo : acc;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_ALU: begin
        add_x   = {1'b0, opa};
        add_y   = {1'b0, opb};
        add_sub = (op != OP_ADD);
      end
      S_NEG_A: begin
        add_y   = {1'b0, opa};
        add_sub = 1'b1;
      end
      S_NEG_B: begin
        add_y   = {1'b0, opb};
        add_sub = 1'b1;
      end
      S_ITER: begin
        if (op == OP_MUL) begin
          add_x = {1'b0, acc};
          add_y = {1'b0, opa};
        end else begin
          add_x   = {acc, div_bit};
          add_y   = {1'b0, opb};
          add_sub = 1'b1;
        end
      end
      S_FIX: begin
        add_y   = {1'b0, fix_val};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum   = (DW+2)'(add_x) + (DW+2)'(add_y ^ {(DW+1){add_sub}}) + (DW+2)'(add_sub);
  // On a subtract, the top carry is set exactly when x >= y.
  assign carry = sum[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid && item_ready) begin
            op    <= item.opcode;
            opa   <= in_a;
            opb   <= in_b;
            neg_a <= in_neg_a;
            neg_b <= in_neg_b;
            if (item.opcode > OP_LT) begin
              res          <= '0;
              res_unknown  <= 1'b0;
              result_valid <= 1'b1;
            end else if (item.a_unknown || item.b_unknown) begin
              res          <= '0;
              res_unknown  <= 1'b1;
              result_valid <= 1'b1;
            end else begin
              case (item.opcode) inside
                OP_ADD, OP_SUB, OP_LT: state <= S_ALU;
                default:               state <= S_NEG_A;
              endcase
            end
          end
        end
        S_ALU: begin
          res_unknown  <= 1'b0;
          result_valid <= 1'b1;
          state        <= S_IDLE;
          if (op == OP_LT) begin
            if (neg_a != neg_b) begin
              res <= DW'(neg_a);
            end else begin
              res <= DW'(!carry);
            end
          end else begin
            res <= sum[DW-1:0] & mask;
          end
        end
        S_NEG_A: begin
          if (neg_a) begin
            opa <= sum[DW-1:0] & mask;
          end
          state <= S_NEG_B;
        end
        S_NEG_B: begin
          if (neg_b) begin
            opb <= sum[DW-1:0] & mask;
          end
          acc   <= '0;
          quo   <= '0;
          cnt   <= width;
          state <= S_ITER;
        end
        S_ITER: begin
          if (op == OP_MUL) begin
            if (opb[0]) begin
              acc <= sum[DW-1:0];
            end
            opa <= {opa[DW-2:0], 1'b0};
            opb <= {1'b0, opb[DW-1:1]};
          end else begin
            // Restoring step: keep the difference only when it did not borrow.
            if (carry) begin
              acc <= sum[DW-1:0];
            end else begin
              acc <= {acc[DW-2:0], div_bit};
            end
            quo <= {quo[DW-2:0], carry};
          end
          cnt <= cnt_m1;
          if (cnt == WIDTH_W'(1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          res          <= (fix_neg ? sum[DW-1:0] : fix_val) & mask;
          res_unknown  <= 1'b0;
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item_ready            = (state == S_IDLE) && !result_valid;
  assign result.result_value   = FIELD_W'(res);
  assign result.result_unknown = res_unknown;

`ifndef SYNTHESIS
  a_ready_excl : assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !result_valid)
    else $error("input ready while a result is pending");

  a_cnt_live : assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> (cnt != '0))
    else $error("iteration counter empty during iteration");

  a_busy_after : assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("input taken again before the item finished");

  a_fix_done : assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |=> (result_valid && (state == S_IDLE)))
    else $error("final step did not present a result");

  a_unknown_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.result_unknown) |-> (result.result_value == '0))
    else $error("unknown result carries nonzero bits");
`endif

endmodule

// File: hw/rtl/four_state_integer_alu.sv
// Top level of the four-state integer ALU: configuration register and core.
// Depends on fsia_pkg and fsia_core.
`timescale 1ns / 1ps

// An item with an unknown operand or an unused opcode presents its result in
// the cycle after its transfer. Add, subtract and less-than go through the ALU
// state. For multiply, divide and remainder, with w the effective operand
// width (1 to 64), one shared adder does two operand negations, then
// one shift-add or shift-subtract step per bit, then the sign fix-up. One
// item is in flight at a time, and the next is taken once the result has
// been transferred. operand_width sits at byte address 0; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module four_state_integer_alu #(
  parameter int MAX_WIDTH = fsia_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsia_pkg::PADDR_W-1:0]  paddr,
  input  logic [fsia_pkg::PDATA_W-1:0]  pwdata,
  output logic [fsia_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  fsia_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output fsia_pkg::result_t             result
);
  import fsia_pkg::*;

  localparam int DW = (MAX_WIDTH < FIELD_W) ? MAX_WIDTH : FIELD_W;
  localparam int WW = $clog2(DW + 1);

  logic [CFG_WIDTH_W-1:0] operand_width;
  logic [WW-1:0]          width;

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_width <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      operand_width <= pwdata[CFG_WIDTH_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : PDATA_W'(operand_width);

  // Zero acts as one bit; anything beyond the datapath clamps to it.
  always_comb begin
    if (operand_width == '0) begin
      width = WW'(1);
    end else if (int'(operand_width) > DW) begin
      width = WW'(DW);
    end else begin
      width = WW'(operand_width);
    end
  end

  fsia_core #(
    .DATA_WIDTH (DW),
    .WIDTH_W    (WW)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .width        (width),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: tb/sv/four_state_integer_alu_tb.sv
// Self-checking testbench for the four-state integer ALU: a built-in predictor
// checks every result transfer, across widths, idling patterns and back-pressure.
// Depends on fsia_pkg and the four_state_integer_alu RTL.
`timescale 1ns / 1ps

module four_state_integer_alu_tb;
  import fsia_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = MAX_WIDTH_DEF + 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic [PADDR_W-1:0]  ADDR_OPERAND_WIDTH = '0;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO       = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI       = 3'd7;

  localparam logic [FIELD_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [FIELD_W-1:0] MOST_NEG  = 64'h8000_0000_0000_0000;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;

  // Testbench copy of operand_width, updated when the write completes.
  logic [CFG_WIDTH_W-1:0] width_cfg = WIDTH_RESET;
  result_t                pending_results[$];
  int                     mismatch_count = 0;
  int                     results_seen = 0;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  logic                   result_hold = 1'b0;

  four_state_integer_alu #(
    .MAX_WIDTH(MAX_WIDTH_DEF)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int eff_width(input logic [CFG_WIDTH_W-1:0] cfg);
    int w;
    w = int'(cfg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (w > FIELD_W) w = FIELD_W;
    return w;
  endfunction

  function automatic result_t alu_result_for(input item_t it, input logic [CFG_WIDTH_W-1:0] cfg);
    int                 w;
    logic [FIELD_W-1:0] m, a, b, mag_a, mag_b, res, rmd;
    logic               neg_a, neg_b;
    result_t            r;
    w = eff_width(cfg);
    m = (w >= FIELD_W) ? ALL_ONES : ((64'd1 << w) - 64'd1);
    a = it.operand_a & m;
    b = it.operand_b & m;
    neg_a = it.both_signed && a[w-1];
    neg_b = it.both_signed && b[w-1];
    mag_a = neg_a ? ((64'd0 - a) & m) : a;
    mag_b = neg_b ? ((64'd0 - b) & m) : b;
    res = '0;
    r = '0;
    if (it.opcode > OP_LT) return r;
    if (it.a_unknown || it.b_unknown) begin
      r.result_unknown = 1'b1;
      return r;
    end
    case (it.opcode)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: begin
        res = mag_a * mag_b;
        if (neg_a != neg_b) res = 64'd0 - res;
      end
      OP_DIV: begin
        // A zero divisor lets every shift-subtract step succeed: all ones.
        res = (mag_b == '0) ? m : mag_a / mag_b;
        if (neg_a != neg_b) res = 64'd0 - res;
      end
      OP_REM: begin
        rmd = (mag_b == '0) ? mag_a : mag_a % mag_b;
        res = neg_a ? (64'd0 - rmd) : rmd;
      end
      default: begin
        // Equal signs compare correctly as raw bits, negative or not.
        if (neg_a != neg_b) res = {63'd0, neg_a};
        else res = {63'd0, a < b};
      end
    endcase
    r.result_value = res & m;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // Receiver: random stalls, or a long hold-off while result_hold is set.
  always @(posedge clk) begin
    if (result_hold) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result check first, then the prediction for an item accepted at this edge.
  always @(posedge clk) begin : result_check
    result_t exp_r;
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d: none expected, got value %h unknown %b",
                                    results_seen, result.result_value, result.result_unknown));
        end else begin
          exp_r = pending_results.pop_front();
          if (result.result_value !== exp_r.result_value)
            report_mismatch($sformatf("result %0d: result_value expected %h actual %h",
                                      results_seen, exp_r.result_value, result.result_value));
          if (result.result_unknown !== exp_r.result_unknown)
            report_mismatch($sformatf("result %0d: result_unknown expected %b actual %b",
                                      results_seen, exp_r.result_unknown,
                                      result.result_unknown));
        end
      end
      if (item_valid && item_ready) pending_results.push_back(alu_result_for(item, width_cfg));
    end
  end

  function automatic item_t make_item(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] a,
                                      input logic [FIELD_W-1:0] b, input logic ua,
                                      input logic ub, input logic sg);
    item_t it;
    it.opcode      = op;
    it.operand_a   = a;
    it.operand_b   = b;
    it.a_unknown   = ua;
    it.b_unknown   = ub;
    it.both_signed = sg;
    return it;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_operand(input int w);
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 64'd1;
      2: v = ALL_ONES;
      3: v = 64'd1 << (w - 1);
      4: v = (64'd1 << (w - 1)) - 64'd1;
      5: v = 64'($urandom_range(0, 15));
      6: v = 64'd0 - 64'($urandom_range(1, 15));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic item_t random_item();
    int    w;
    item_t it;
    w = eff_width(width_cfg);
    if ($urandom_range(0, 24) == 0)
      it.opcode = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else it.opcode = OPCODE_W'($urandom_range(OP_ADD, OP_LT));
    it.operand_a   = pick_operand(w);
    it.operand_b   = pick_operand(w);
    it.a_unknown   = ($urandom_range(0, 9) == 0);
    it.b_unknown   = ($urandom_range(0, 9) == 0);
    it.both_signed = ($urandom_range(0, 1) == 1);
    return it;
  endfunction

  // Offers one item and returns at the edge of its transfer, valid still high.
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  // The prediction of the last transfer is queued at its edge, so wait past that edge.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write operand_width, then read it back.
  task automatic set_operand_width(input logic [CFG_WIDTH_W-1:0] w);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_OPERAND_WIDTH;
    pwdata  <= PDATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    width_cfg = w;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_WIDTH_W-1:0] !== w)
      report_mismatch($sformatf("operand_width read back expected %0d actual %0d",
                                w, prdata[CFG_WIDTH_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Corner cases at the reset width of 64 bits.
  task automatic test_directed_cases();
    send_item(make_item(OP_ADD, ALL_ONES, ALL_ONES, 0, 0, 0));
    send_item(make_item(OP_ADD, '0, '0, 0, 0, 1));
    send_item(make_item(OP_SUB, '0, 64'd1, 0, 0, 0));
    send_item(make_item(OP_SUB, MOST_NEG, 64'd1, 0, 0, 1));
    send_item(make_item(OP_MUL, ALL_ONES, ALL_ONES, 0, 0, 0));
    send_item(make_item(OP_MUL, MOST_NEG, ALL_ONES, 0, 0, 1));
    send_item(make_item(OP_MUL, ALL_ONES, 64'd3, 0, 0, 1));
    send_item(make_item(OP_DIV, 64'd100, '0, 0, 0, 0));
    send_item(make_item(OP_DIV, ALL_ONES, '0, 0, 0, 1));
    send_item(make_item(OP_DIV, MOST_NEG, ALL_ONES, 0, 0, 1));
    send_item(make_item(OP_DIV, ALL_ONES, 64'd7, 0, 0, 0));
    send_item(make_item(OP_REM, 64'd0 - 64'd7, 64'd2, 0, 0, 1));
    send_item(make_item(OP_REM, 64'd12345, '0, 0, 0, 0));
    send_item(make_item(OP_REM, 64'd7, 64'd0 - 64'd2, 0, 0, 1));
    send_item(make_item(OP_LT, ALL_ONES, 64'd1, 0, 0, 1));
    send_item(make_item(OP_LT, 64'd1, ALL_ONES, 0, 0, 1));
    send_item(make_item(OP_LT, ALL_ONES, 64'd1, 0, 0, 0));
    send_item(make_item(OP_LT, MOST_NEG, ALL_ONES, 0, 0, 1));
    send_item(make_item(OP_LT, 64'd42, 64'd42, 0, 0, 0));
    send_item(make_item(OP_ADD, 64'd5, 64'd6, 1, 0, 0));
    send_item(make_item(OP_DIV, 64'd5, '0, 0, 1, 1));
    send_item(make_item(OP_MUL, ALL_ONES, ALL_ONES, 1, 1, 1));
    send_item(make_item(OP_UNUSED_LO, 64'd9, 64'd3, 1, 0, 0));
    send_item(make_item(OP_UNUSED_HI, ALL_ONES, MOST_NEG, 0, 1, 1));
    drain();
  endtask

  // Widths at and beyond the legal range, with operand bits above the width.
  task automatic test_width_extremes();
    logic [CFG_WIDTH_W-1:0] widths[6] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd63};
    foreach (widths[i]) begin
      set_operand_width(widths[i]);
      repeat (5) send_item(random_item());
      drain();
    end
  endtask

  task automatic test_random_phases();
    int                     send_pct[4] = '{0, 62, 0, 36};
    int                     recv_pct[4] = '{0, 0, 62, 36};
    logic [CFG_WIDTH_W-1:0] extreme[4] = '{7'd64, 7'd1, 7'd0, 7'd127};
    logic [CFG_WIDTH_W-1:0] w;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct <= recv_pct[p];
      for (int k = 0; k < 3; k++) begin
        if (k == 0) w = extreme[p];
        else if (k == 1) w = CFG_WIDTH_W'($urandom_range(1, 64));
        else w = CFG_WIDTH_W'($urandom_range(0, 127));
        set_operand_width(w);
        repeat (75) send_item(random_item());
        drain();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct <= 0;
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    set_operand_width(7'd64);
    fork
      begin
        result_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_hold <= 1'b0;
      end
    join_none
    repeat (16) send_item(random_item());
    drain();
  endtask

  initial begin
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_width_extremes();
    test_random_phases();
    test_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("four_state_integer_alu_tb OK");
    end else begin
      $display("four_state_integer_alu_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("four_state_integer_alu_tb NOT OK");
    $finish;
  end

endmodule

// File: four_state_integer_alu.f
hw/rtl/fsia_pkg.sv
hw/rtl/fsia_core.sv
hw/rtl/four_state_integer_alu.sv
tb/sv/four_state_integer_alu_tb.sv
